/* hdl/spq_pkg.sv */
package spq_pkg;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

endpackage

/* hdl/spq_front.sv */
module spq_front #(
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  input  logic [TAG_BITS-1:0]  in_tag_i,
  input  logic [PRIO_BITS-1:0] in_prio_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output spq_pkg::req_e        cmd_req_o,
  output logic [TAG_BITS-1:0]  cmd_tag_o,
  output logic [PRIO_BITS-1:0] cmd_prio_o
);

  logic                 valid_q;
  spq_pkg::req_e        req_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic                 take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Tag and priority only matter to an enqueue; clear them for a dequeue.
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= spq_pkg::req_e'(in_kind_i);
      if (spq_pkg::req_e'(in_kind_i) == spq_pkg::REQ_ENQ) begin
        tag_q  <= in_tag_i;
        prio_q <= in_prio_i;
      end else begin
        tag_q  <= '0;
        prio_q <= '0;
      end
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_req_o   = req_q;
  assign cmd_tag_o   = tag_q;
  assign cmd_prio_o  = prio_q;

endmodule

/* hdl/spq_fifo.sv */
module spq_fifo #(
  parameter int WIDTH = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/spq_back.sv */
module spq_back #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 8,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  spq_pkg::req_e        cmd_req_i,
  input  logic [TAG_BITS-1:0]  cmd_tag_i,
  input  logic [PRIO_BITS-1:0] cmd_prio_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output spq_pkg::status_e     res_status_o,
  output logic [TAG_BITS-1:0]  res_tag_o,
  output logic [PRIO_BITS-1:0] res_prio_o,
  output logic [CNT_W-1:0]     count_o
);

  // Slot 0 is the head; held slots are 0 .. cnt_q-1 in service order.
  logic [TAG_BITS-1:0]  tag_q  [DEPTH];
  logic [PRIO_BITS-1:0] prio_q [DEPTH];
  logic [TAG_BITS-1:0]  tag_d  [DEPTH];
  logic [PRIO_BITS-1:0] prio_d [DEPTH];
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cnt_d;
  logic [DEPTH-1:0]     keep;

  logic                 out_valid_q;
  spq_pkg::status_e     status_q;
  spq_pkg::status_e     status_d;
  logic [TAG_BITS-1:0]  served_tag_q;
  logic [TAG_BITS-1:0]  served_tag_d;
  logic [PRIO_BITS-1:0] served_prio_q;
  logic [PRIO_BITS-1:0] served_prio_d;

  logic fire;
  logic is_full;
  logic is_empty;
  logic do_enq;
  logic do_deq;

  assign cmd_ready_o = !out_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign is_full     = (cnt_q == CNT_W'(DEPTH));
  assign is_empty    = (cnt_q == '0);
  assign do_enq      = fire && (cmd_req_i == spq_pkg::REQ_ENQ) && !is_full;
  assign do_deq      = fire && (cmd_req_i == spq_pkg::REQ_DEQ) && !is_empty;

  // Each slot decides on its own: hold, take the new item, or shift.
  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    logic [TAG_BITS-1:0]  up_tag;
    logic [PRIO_BITS-1:0] up_prio;
    logic [TAG_BITS-1:0]  dn_tag;
    logic [PRIO_BITS-1:0] dn_prio;
    logic                 prev_keep;

    assign keep[k] = (CNT_W'(k) < cnt_q) && (prio_q[k] >= cmd_prio_i);

    if (k == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign dn_tag    = cmd_tag_i;
      assign dn_prio   = cmd_prio_i;
    end else begin : g_inner
      assign prev_keep = keep[k-1];
      assign dn_tag    = tag_q[k-1];
      assign dn_prio   = prio_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign up_tag  = tag_q[k];
      assign up_prio = prio_q[k];
    end else begin : g_body
      assign up_tag  = tag_q[k+1];
      assign up_prio = prio_q[k+1];
    end

    always_comb begin
      tag_d[k]  = tag_q[k];
      prio_d[k] = prio_q[k];
      if (do_enq && !keep[k]) begin
        if (prev_keep) begin
          tag_d[k]  = cmd_tag_i;
          prio_d[k] = cmd_prio_i;
        end else begin
          tag_d[k]  = dn_tag;
          prio_d[k] = dn_prio;
        end
      end else if (do_deq) begin
        tag_d[k]  = up_tag;
        prio_d[k] = up_prio;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k]  <= tag_d[k];
      prio_q[k] <= prio_d[k];
    end
  end

  always_comb begin
    cnt_d         = cnt_q;
    status_d      = spq_pkg::ST_ADDED;
    served_tag_d  = '0;
    served_prio_d = '0;
    case (cmd_req_i)
      spq_pkg::REQ_ENQ: begin
        if (is_full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          status_d = spq_pkg::ST_ADDED;
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      spq_pkg::REQ_DEQ: begin
        if (is_empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          status_d      = spq_pkg::ST_SERVED;
          served_tag_d  = tag_q[0];
          served_prio_d = prio_q[0];
          cnt_d         = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = spq_pkg::ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q <= cnt_d;
      end
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      served_tag_q  <= served_tag_d;
      served_prio_q <= served_prio_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = status_q;
  assign res_tag_o    = served_tag_q;
  assign res_prio_o   = served_prio_q;
  assign count_o      = cnt_q;

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue of tagged entries, DEPTH slots deep.
// Request channel (s_axis): tuser[0] selects enqueue (0) or dequeue (1);
// tdata carries the tag and the priority of an enqueue.
// Result channel (m_axis): one item per request. tuser is the status
// (added, full, served, empty); tdata holds the served tag and priority,
// zero unless the status is served.
// Higher priority is served first; equal priorities leave in arrival order.
// An enqueue to a full queue and a dequeue from an empty one leave the
// contents untouched.
// Path: a request passes the front register, the two-entry command queue
// and the result register before its result is valid on m_axis.
// Throughput: one request per cycle while m_axis_tready_i stays high; the
// back end compares the new priority against all slots in parallel and
// shifts the whole slot row together.
// Reset empties the queue; slot contents need no clearing and none is done.
// When the receiver stalls, the result register holds, the command queue
// fills, and s_axis_tready_o drops once the front register is also full.
module sorted_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // [TAG_BITS-1:0] entry_tag, [TAG_BITS+PRIO_BITS-1:TAG_BITS] entry_priority
  input  logic [((TAG_BITS+PRIO_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // [0] req_type
  input  logic [0:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // [TAG_BITS-1:0] served_tag, [TAG_BITS+PRIO_BITS-1:TAG_BITS] served_priority
  output logic [((TAG_BITS+PRIO_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0] m_axis_tuser_o
);

  localparam int DATA_W = ((TAG_BITS + PRIO_BITS + 7) / 8) * 8;
  localparam int CMD_W  = 1 + TAG_BITS + PRIO_BITS;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic                 f_valid;
  logic                 f_ready;
  spq_pkg::req_e        f_req;
  logic [TAG_BITS-1:0]  f_tag;
  logic [PRIO_BITS-1:0] f_prio;

  logic                 q_valid;
  logic                 q_ready;
  logic [CMD_W-1:0]     q_data;

  spq_pkg::status_e     res_status;
  logic [TAG_BITS-1:0]  res_tag;
  logic [PRIO_BITS-1:0] res_prio;
  logic [CNT_W-1:0]     count;

  spq_front #(
    .TAG_BITS (TAG_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i[0]),
    .in_tag_i   (s_axis_tdata_i[TAG_BITS-1:0]),
    .in_prio_i  (s_axis_tdata_i[TAG_BITS +: PRIO_BITS]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_req_o  (f_req),
    .cmd_tag_o  (f_tag),
    .cmd_prio_o (f_prio)
  );

  spq_fifo #(
    .WIDTH(CMD_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_prio, f_tag, f_req}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  spq_back #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .PRIO_BITS(PRIO_BITS),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_req_i   (spq_pkg::req_e'(q_data[0])),
    .cmd_tag_i   (q_data[TAG_BITS:1]),
    .cmd_prio_i  (q_data[CMD_W-1:TAG_BITS+1]),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_status_o(res_status),
    .res_tag_o   (res_tag),
    .res_prio_o  (res_prio),
    .count_o     (count)
  );

  assign m_axis_tdata_o = DATA_W'({res_prio, res_tag});
  assign m_axis_tuser_o = res_status;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_full_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res_status == spq_pkg::ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full status while queue not full");

  a_empty_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res_status == spq_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty status while queue holds entries");

  a_idle_data_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res_status != spq_pkg::ST_SERVED) |-> m_axis_tdata_o == '0)
    else $error("nonzero served fields without a served entry");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] tag;
  logic [7:0]  prio;
} pq_entry_t;

typedef struct packed {
  spq_pkg::status_e status;
  logic [15:0]      tag;
  logic [7:0]       prio;
} pq_result_t;

// Mirror of the queue contents, head first, plus the results still owed.
class pq_tracker;
  pq_entry_t  held[$];
  pq_result_t due_results[$];
  int         depth;
  int         errors;
  int         status_seen[4];
  int         full_hits;

  function new(int depth_arg);
    depth  = depth_arg;
    errors = 0;
    full_hits = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void note_request(spq_pkg::req_e req, logic [15:0] tag, logic [7:0] prio);
    pq_result_t res;
    pq_entry_t  ent;
    int         pos;
    res.status = spq_pkg::ST_ADDED;
    res.tag    = '0;
    res.prio   = '0;
    if (req == spq_pkg::REQ_ENQ) begin
      if (held.size() >= depth) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // go behind every entry of greater or equal priority
        pos = held.size();
        for (int k = 0; k < held.size(); k++) begin
          if (held[k].prio < prio) begin
            pos = k;
            break;
          end
        end
        ent.tag  = tag;
        ent.prio = prio;
        held.insert(pos, ent);
        if (held.size() == depth) full_hits++;
      end
    end else if (held.size() == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      res.status = spq_pkg::ST_SERVED;
      res.tag    = held[0].tag;
      res.prio   = held[0].prio;
      void'(held.pop_front());
    end
    due_results.push_back(res);
  endfunction

  function void check_result(logic [1:0] status, logic [15:0] tag, logic [7:0] prio);
    pq_result_t exp_res;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result item: status %0d tag %h prio %h",
               $time, status, tag, prio);
      errors++;
      return;
    end
    exp_res = due_results.pop_front();
    status_seen[status]++;
    if (status !== exp_res.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d",
               $time, exp_res.status, status);
      errors++;
    end
    if (tag !== exp_res.tag) begin
      $display("%0t: served_tag mismatch: expected %h actual %h", $time, exp_res.tag, tag);
      errors++;
    end
    if (prio !== exp_res.prio) begin
      $display("%0t: served_priority mismatch: expected %h actual %h",
               $time, exp_res.prio, prio);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int QUEUE_DEPTH = 16;
  localparam int RAND_ITEMS  = 2000;
  localparam int IDLE_LIMIT  = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  logic [31:0] rx_cycle = '0;
  int          idle_cycles = 0;
  int          sent = 0;
  pq_tracker   board = new(QUEUE_DEPTH);

  sorted_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver: change stall behavior as rx_cycle[10:9] steps through four modes
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[10:9])
      2'd0:    m_axis_tready_i <= 1'b1;
      2'd1:    m_axis_tready_i <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (rx_cycle[2:0] < 3'd2);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[23:16]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input spq_pkg::req_e req, input logic [15:0] tag,
                              input logic [7:0] prio);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {prio, tag};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(req, tag, prio);
    sent++;
  endtask

  task automatic pause(input int cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.due_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 8'($urandom_range(0, 255));
    if (sel < 8) return 8'($urandom_range(0, 3));
    return (sel == 8) ? 8'h00 : 8'hff;
  endfunction

  initial begin
    int            enq_pct;
    int            phase_left;
    int            burst_left;
    spq_pkg::req_e req;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dequeue, field extremes, ties at the top, fill to refusal
    send_request(spq_pkg::REQ_DEQ, 16'hffff, 8'hff);
    send_request(spq_pkg::REQ_ENQ, 16'hffff, 8'hff);
    send_request(spq_pkg::REQ_ENQ, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_ENQ, 16'h1234, 8'hff);
    send_request(spq_pkg::REQ_ENQ, 16'ha5a5, 8'h80);
    send_request(spq_pkg::REQ_DEQ, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_DEQ, 16'h0000, 8'h00);
    for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
      send_request(spq_pkg::REQ_ENQ, 16'h5a00 + 16'(i),
                   (i % 3 == 0) ? 8'h80 : (i % 3 == 1) ? 8'h00 : 8'hff);
    end
    send_request(spq_pkg::REQ_ENQ, 16'hbeef, 8'hff);

    // random: phases biased toward filling, draining or churning
    enq_pct    = 50;
    phase_left = 0;
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          2:       enq_pct = 50;
          default: enq_pct = 58;
        endcase
      end
      phase_left--;
      req = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
      send_request(req, 16'($urandom), pick_priority());
      if (n == RAND_ITEMS / 2) begin
        wait_drained();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("%0d requests: %0d added, %0d refused full, %0d served, %0d on empty queue",
             sent, board.status_seen[spq_pkg::ST_ADDED],
             board.status_seen[spq_pkg::ST_FULL],
             board.status_seen[spq_pkg::ST_SERVED],
             board.status_seen[spq_pkg::ST_EMPTY]);
    $display("queue reached full depth %0d times; %0d mismatches",
             board.full_hits, board.errors);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/spq_pkg.sv
hdl/spq_front.sv
hdl/spq_fifo.sv
hdl/spq_back.sv
hdl/sorted_priority_queue.sv
bench/tb.sv
